// ===== hw/rtl/svfc_pkg.sv =====
package svfc_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned UsedW      = $clog2(TableDepth + 1);
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 16;
  localparam int unsigned EntryW     = ValueW + CountW;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     final_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        entry_count;
    logic                     table_overflowed;
    logic                     last_entry;
  } out_item_t;

endpackage

// ===== hw/rtl/svfc_stream_if.sv =====
interface svfc_in_if;
  import svfc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface svfc_out_if;
  import svfc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/svfc_ram.sv =====
module svfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hw/rtl/sorted_value_frequency_counter_core.sv =====
// an item, accept to next accept, on a table of n entries: accept, scan one entry per cycle,
//   fit check, shift-by-one walking down from the top, then the write of the new entry;
//   a match ends after its scan, a full table sets overflow at the fit check, an empty table skips to the write
// a final item then emits each entry with a ram read and an output register load, held while the
//   receiver stalls; the next item is accepted once the last result is loaded
// reset: asynchronous active low, clears the state, fill count, overflow flag and output valid; the table
//   ram is not cleared since only entries below the fill count are ever read
module sorted_value_frequency_counter_core
  import svfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  svfc_in_if.sink    in_i,
  svfc_out_if.source out_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StScan  = 7'b0000010,
    StCheck = 7'b0000100,
    StShift = 7'b0001000,
    StPut   = 7'b0010000,
    StEmit  = 7'b0100000,
    StWait  = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [UsedW-1:0]         used_q, used_d;
  logic                     ovf_q, ovf_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic                     fin_q, fin_d;
  logic [UsedW-1:0]         idx_q, idx_d;   // scan / shift / emit pointer
  logic [UsedW-1:0]         pos_q, pos_d;
  logic                     ovalid_q, ovalid_d;
  out_item_t                opay_q, opay_d;

  // ram port signals
  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic signed [ValueW-1:0] rd_val;
  logic [CountW-1:0]        rd_cnt;

  assign rd_val = rdata[EntryW-1:CountW];
  assign rd_cnt = rdata[CountW-1:0];

  svfc_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic out_free;
  assign out_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid   = ovalid_q;
  assign out_o.payload = opay_q;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    ovf_d    = ovf_q;
    val_d    = val_q;
    fin_d    = fin_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q && !out_o.ready;
    opay_d   = opay_q;
    we       = 1'b0;
    waddr    = idx_q[IdxW-1:0];
    wdata    = {rd_val, rd_cnt};
    raddr    = idx_q[IdxW-1:0];
    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          val_d = in_i.payload.value;
          fin_d = in_i.payload.final_value;
          idx_d = '0;
          if (used_q == '0) begin
            pos_d   = '0;
            state_d = StPut;
          end else begin
            state_d = StScan;  // read of entry 0 issued
          end
        end
      end
      // rdata holds entry idx_q
      StScan: begin
        if (rd_val < val_q) begin
          if (idx_q + 1'b1 == used_q) begin
            pos_d   = used_q;
            state_d = StCheck;
          end else begin
            idx_d = idx_q + 1'b1;
            raddr = idx_d[IdxW-1:0];
          end
        end else if (rd_val == val_q) begin
          we    = 1'b1;
          wdata = {rd_val, (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 1'b1};
          state_d = fin_q ? StEmit : StIdle;
          idx_d = '0;
        end else begin
          pos_d   = idx_q;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (used_q == UsedW'(TableDepth)) begin
          ovf_d   = 1'b1;
          idx_d   = '0;
          state_d = fin_q ? StEmit : StIdle;
        end else if (pos_q == used_q) begin
          state_d = StPut;
        end else begin
          idx_d   = used_q - 1'b1;
          raddr   = idx_d[IdxW-1:0];
          state_d = StShift;
        end
      end
      // rdata holds entry idx_q, move it up one
      StShift: begin
        we    = 1'b1;
        waddr = IdxW'(idx_q + 1'b1);
        if (idx_q == pos_q) begin
          state_d = StPut;
        end else begin
          idx_d = idx_q - 1'b1;
          raddr = idx_d[IdxW-1:0];
        end
      end
      StPut: begin
        we      = 1'b1;
        waddr   = pos_q[IdxW-1:0];
        wdata   = {val_q, CountW'(1)};
        used_d  = used_q + 1'b1;
        idx_d   = '0;
        state_d = fin_q ? StEmit : StIdle;
      end
      StEmit: begin
        raddr   = idx_q[IdxW-1:0];
        state_d = StWait;
      end
      StWait: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          opay_d.entry_value      = rd_val;
          opay_d.entry_count      = rd_cnt;
          opay_d.table_overflowed = ovf_q;
          opay_d.last_entry       = (idx_q + 1'b1 == used_q);
          if (idx_q + 1'b1 == used_q) begin
            used_d  = '0;
            ovf_d   = 1'b0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StEmit;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      used_q   <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    fin_q  <= fin_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    opay_q <= opay_d;
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TableDepth)) else $error("fill count beyond depth");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> used_q != '0) else $error("emit of empty table");
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StWait) |-> idx_q < used_q)
    else $error("emit pointer beyond fill count");
  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StShift |-> idx_q >= pos_q) else $error("shift below insert point");
`endif

endmodule

// ===== dv/svfc_checker.sv =====
module svfc_checker
  import svfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  svfc_in_if.sink     in_mon,
  svfc_out_if.sink    out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [ValueW-1:0] tbl_value [TableDepth];
  logic [CountW-1:0]        tbl_count [TableDepth];
  int unsigned              tbl_used;
  logic                     tbl_overflow;
  out_item_t                expected_entries [$];

  assign pending_o = expected_entries.size();

  // insert or count one value, then dump the table when it closes a run
  task automatic count_and_emit(input in_item_t it);
    int unsigned pos;
    out_item_t   e;
    pos = 0;
    while (pos < tbl_used && tbl_value[pos] < it.value) pos++;
    if (pos < tbl_used && tbl_value[pos] == it.value) begin
      if (tbl_count[pos] != CountMax) tbl_count[pos]++;
    end else if (tbl_used >= TableDepth) begin
      tbl_overflow = 1'b1;
    end else begin
      for (int k = tbl_used; k > pos; k--) begin
        tbl_value[k] = tbl_value[k-1];
        tbl_count[k] = tbl_count[k-1];
      end
      tbl_value[pos] = it.value;
      tbl_count[pos] = CountW'(1);
      tbl_used++;
    end
    if (it.final_value) begin
      for (int k = 0; k < tbl_used; k++) begin
        e.entry_value      = tbl_value[k];
        e.entry_count      = tbl_count[k];
        e.table_overflowed = tbl_overflow;
        e.last_entry       = (k + 1 == tbl_used);
        expected_entries.push_back(e);
      end
      tbl_used     = 0;
      tbl_overflow = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      tbl_used     = 0;
      tbl_overflow = 1'b0;
      expected_entries.delete();
      fail_count_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) count_and_emit(in_mon.payload);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected entry %0d count %0d", $time,
                   got.entry_value, got.entry_count);
          fail_count_o++;
        end else begin
          want = expected_entries.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected val %0d cnt %0d ovf %0b last %0b",
                     $time, want.entry_value, want.entry_count,
                     want.table_overflowed, want.last_entry);
            $display("%0t:          actual   val %0d cnt %0d ovf %0b last %0b",
                     $time, got.entry_value, got.entry_count,
                     got.table_overflowed, got.last_entry);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_sorted_value_frequency_counter_core.sv =====
module tb_sorted_value_frequency_counter_core;
  import svfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  bit          calm;     // no idling near the end of the run

  svfc_in_if  in_ch ();
  svfc_out_if out_ch ();

  sorted_value_frequency_counter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  svfc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // drive one item, with an optional idle burst in front
  task automatic send_item(input logic signed [ValueW-1:0] v, input logic fin);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         = 1'b1;
    in_ch.payload.value = v;
    in_ch.payload.final_value = fin;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // values mostly drawn from small pools so repeats and sorting get exercised
  function automatic logic signed [ValueW-1:0] pick_value(input int unsigned spread);
    case ($urandom_range(0, 3))
      0: pick_value = $urandom;
      1: pick_value = 32'sh7FFF_FFF0 + $urandom_range(0, 15);
      2: pick_value = 32'sh8000_0000 + $urandom_range(0, 15);
      default: pick_value = $signed($urandom_range(0, spread)) - $signed(spread / 2);
    endcase
  endfunction

  initial begin
    int unsigned n_items;
    int unsigned run_len;
    int unsigned spread;
    cycles           = 0;
    calm             = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.payload    = '0;
    rst_ni           = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, a lone final, duplicates out of order
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0, 1'b0);
    send_item(-32'sh1, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh5, 1'b1);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b0);
    send_item(32'sh5555_5555, 1'b1);

    // fill past the table depth: overflow, and a dropped final item
    for (int k = 0; k < TableDepth + 3; k++) send_item(k * 3 - 90, 1'b0);
    send_item(32'sh7FFF_0000, 1'b1);
    for (int k = 0; k < TableDepth; k++) send_item(TableDepth - k, 1'b0);
    send_item(-32'sh7, 1'b1);

    // random runs of varied length
    n_items = 0;
    while (n_items < 360) begin
      run_len = $urandom_range(1, 40);
      if ($urandom_range(0, 9) == 0) run_len = $urandom_range(60, 90);
      spread = $urandom_range(2, 120);
      if (n_items > 290) calm = 1'b1;
      for (int k = 1; k <= run_len; k++)
        send_item(pick_value(spread), k == run_len);
      n_items += run_len;
    end

    calm = 1'b1;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
